[sv/cle_pkg.sv]
// package for the circular list engine: pool sizing, request and status codes,
// and the request/response structs between the sequencer and the node store
// no dependencies
`timescale 1ns / 1ps

package cle_pkg;

    // pool sizing
    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    // port field widths
    localparam int REQ_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int HANDLE_W   = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_AFTER = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_NODE  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // accesses issued by the sequencer to the node store
    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               lk_we;
        logic [IDX_W-1:0]   lk_waddr;
        logic [IDX_W-1:0]   lk_wdata;
        logic               vl_we;
        logic [IDX_W-1:0]   vl_waddr;
        logic [VALUE_W-1:0] vl_wdata;
        logic               use_set;
        logic               use_clr;
        logic [IDX_W-1:0]   use_idx;
    } t_mem_req;

    // read data and occupancy returned by the node store
    typedef struct packed {
        logic [IDX_W-1:0]      lk_rdata;
        logic [VALUE_W-1:0]    vl_rdata;
        logic [POOL_DEPTH-1:0] in_use;
        logic [IDX_W-1:0]      free_idx;
        logic                  full;
    } t_store_rsp;

endpackage

[sv/cle_if.sv]
// valid/ready channel interfaces for requests and responses of the list engine
// depends on cle_pkg
`timescale 1ns / 1ps

interface cle_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [cle_pkg::REQ_W-1:0]            req_type;
    logic signed [cle_pkg::VALUE_W-1:0]   value;
    logic [cle_pkg::HANDLE_W-1:0]         handle;

    modport source (output valid, output req_type, output value, output handle,
                    input ready);
    modport sink   (input valid, input req_type, input value, input handle,
                    output ready);
endinterface

interface cle_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [cle_pkg::STATUS_W-1:0]    status;
    logic [cle_pkg::HANDLE_W-1:0]    result_handle;
    logic [cle_pkg::COUNT_W-1:0]     node_count;

    modport source (output valid, output status, output result_handle,
                    output node_count, input ready);
    modport sink   (input valid, input status, input result_handle,
                    input node_count, output ready);
endinterface

[sv/cle_store.sv]
// node store: value and link memories with registered reads, in-use flags
// and the lowest-free-slot encoder
// depends on cle_pkg
`timescale 1ns / 1ps

module cle_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cle_pkg::t_mem_req   i_mreq,
    output cle_pkg::t_store_rsp o_srsp
);

    logic [cle_pkg::IDX_W-1:0]   r_link_mem [cle_pkg::POOL_DEPTH];
    logic [cle_pkg::VALUE_W-1:0] r_value_mem [cle_pkg::POOL_DEPTH];
    logic [cle_pkg::IDX_W-1:0]   r_lk_rdata;
    logic [cle_pkg::VALUE_W-1:0] r_vl_rdata;
    logic [cle_pkg::POOL_DEPTH-1:0] r_in_use;
    logic [cle_pkg::IDX_W-1:0]   w_free_idx;
    logic                        w_full;

    // link memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_mreq.lk_we) begin
            r_link_mem[i_mreq.lk_waddr] <= i_mreq.lk_wdata;
        end
        if (i_mreq.rd_en) begin
            r_lk_rdata <= r_link_mem[i_mreq.rd_addr];
        end
    end

    // value memory, read at the same address as the link memory
    always_ff @(posedge i_clk) begin
        if (i_mreq.vl_we) begin
            r_value_mem[i_mreq.vl_waddr] <= i_mreq.vl_wdata;
        end
        if (i_mreq.rd_en) begin
            r_vl_rdata <= r_value_mem[i_mreq.rd_addr];
        end
    end

    // in-use flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (i_mreq.use_set) begin
            r_in_use[i_mreq.use_idx] <= 1'b1;
        end else if (i_mreq.use_clr) begin
            r_in_use[i_mreq.use_idx] <= 1'b0;
        end
    end

    // lowest free slot
    always_comb begin
        w_free_idx = '0;
        w_full     = &r_in_use;
        for (int i = cle_pkg::POOL_DEPTH - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_free_idx = cle_pkg::IDX_W'(i);
            end
        end
    end

    assign o_srsp.lk_rdata = r_lk_rdata;
    assign o_srsp.vl_rdata = r_vl_rdata;
    assign o_srsp.in_use   = r_in_use;
    assign o_srsp.free_idx = w_free_idx;
    assign o_srsp.full     = w_full;

endmodule

[sv/cle_ctrl.sv]
// request sequencer: decodes each request, walks the links through the node
// store one read per cycle, writes back and holds the response register
// depends on cle_pkg, cle_if and the node store ports
`timescale 1ns / 1ps

module cle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cle_req_if.sink             i_req,
    cle_rsp_if.source           o_rsp,
    output cle_pkg::t_mem_req   o_mreq,
    input  cle_pkg::t_store_rsp i_srsp
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_WR  = 4'd2;
    localparam logic [3:0] S_DEL_X   = 4'd3;
    localparam logic [3:0] S_DEL_NX  = 4'd4;
    localparam logic [3:0] S_WALK    = 4'd5;
    localparam logic [3:0] S_DEL_WR  = 4'd6;
    localparam logic [3:0] S_SRCH0   = 4'd7;
    localparam logic [3:0] S_SRCH    = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    localparam int IW = cle_pkg::IDX_W;
    localparam int CW = cle_pkg::CNT_W;

    logic [3:0]                           r_state, n_state;
    logic [IW-1:0]                        r_tail, n_tail;
    logic [CW-1:0]                        r_count, n_count;
    logic [cle_pkg::REQ_W-1:0]            r_req, n_req;
    logic [cle_pkg::VALUE_W-1:0]          r_val, n_val;
    logic [IW-1:0]                        r_a, n_a;
    logic [IW-1:0]                        r_n, n_n;
    logic [IW-1:0]                        r_x, n_x;
    logic [IW-1:0]                        r_nx, n_nx;
    logic [IW-1:0]                        r_p, n_p;
    logic [CW-1:0]                        r_i, n_i;
    logic [cle_pkg::STATUS_W-1:0]         r_status, n_status;
    logic [IW-1:0]                        r_res, n_res;
    logic                                 r_out_valid, n_out_valid;
    logic [cle_pkg::STATUS_W-1:0]         r_out_status, n_out_status;
    logic [IW-1:0]                        r_out_res, n_out_res;
    logic [CW-1:0]                        r_out_count, n_out_count;

    logic          w_accept;
    logic [IW-1:0] w_hidx;
    logic          w_hok;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_hidx      = IW'(i_req.handle);
    assign w_hok       = (32'(i_req.handle) < 32'(cle_pkg::POOL_DEPTH))
                         && i_srsp.in_use[w_hidx];

    // sequencer next state and store accesses
    always_comb begin
        n_state  = r_state;
        n_tail   = r_tail;
        n_count  = r_count;
        n_req    = r_req;
        n_val    = r_val;
        n_a      = r_a;
        n_n      = r_n;
        n_x      = r_x;
        n_nx     = r_nx;
        n_p      = r_p;
        n_i      = r_i;
        n_status = r_status;
        n_res    = r_res;
        o_mreq   = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req    = i_req.req_type;
                    n_val    = i_req.value;
                    n_status = cle_pkg::ST_MISS;
                    n_res    = '0;
                    n_state  = S_DONE;
                    case (i_req.req_type)
                        cle_pkg::REQ_INS_FRONT, cle_pkg::REQ_INS_BACK,
                        cle_pkg::REQ_INS_AFTER: begin
                            if (i_req.req_type == cle_pkg::REQ_INS_AFTER && !w_hok) begin
                                n_status = cle_pkg::ST_MISS;
                            end else if (i_srsp.full) begin
                                n_status = cle_pkg::ST_FULL;
                            end else begin
                                // claim the slot and store the value now
                                o_mreq.vl_we    = 1'b1;
                                o_mreq.vl_waddr = i_srsp.free_idx;
                                o_mreq.vl_wdata = i_req.value;
                                o_mreq.use_set  = 1'b1;
                                o_mreq.use_idx  = i_srsp.free_idx;
                                n_n             = i_srsp.free_idx;
                                if (r_count == '0) begin
                                    // first node links to itself
                                    o_mreq.lk_we    = 1'b1;
                                    o_mreq.lk_waddr = i_srsp.free_idx;
                                    o_mreq.lk_wdata = i_srsp.free_idx;
                                    n_tail          = i_srsp.free_idx;
                                    n_count         = r_count + 1'b1;
                                    n_status        = cle_pkg::ST_OK;
                                    n_res           = i_srsp.free_idx;
                                end else begin
                                    n_a = (i_req.req_type == cle_pkg::REQ_INS_AFTER)
                                          ? w_hidx : r_tail;
                                    o_mreq.rd_en   = 1'b1;
                                    o_mreq.rd_addr = n_a;
                                    n_state        = S_INS_RD;
                                end
                            end
                        end
                        cle_pkg::REQ_DEL_FIRST, cle_pkg::REQ_DEL_LAST,
                        cle_pkg::REQ_DEL_NODE: begin
                            if (r_count == '0) begin
                                n_status = cle_pkg::ST_EMPTY;
                            end else if (i_req.req_type == cle_pkg::REQ_DEL_NODE
                                         && !w_hok) begin
                                n_status = cle_pkg::ST_MISS;
                            end else if (r_count == CW'(1)) begin
                                // only node: the list becomes empty
                                n_x = (i_req.req_type == cle_pkg::REQ_DEL_NODE)
                                      ? w_hidx : r_tail;
                                o_mreq.use_clr = 1'b1;
                                o_mreq.use_idx = n_x;
                                n_count        = '0;
                                n_tail         = '0;
                                n_status       = cle_pkg::ST_OK;
                                n_res          = n_x;
                            end else if (i_req.req_type == cle_pkg::REQ_DEL_FIRST) begin
                                o_mreq.rd_en   = 1'b1;
                                o_mreq.rd_addr = r_tail;
                                n_state        = S_DEL_X;
                            end else begin
                                n_x = (i_req.req_type == cle_pkg::REQ_DEL_NODE)
                                      ? w_hidx : r_tail;
                                o_mreq.rd_en   = 1'b1;
                                o_mreq.rd_addr = n_x;
                                n_state        = S_DEL_NX;
                            end
                        end
                        cle_pkg::REQ_SEARCH: begin
                            if (r_count != '0) begin
                                o_mreq.rd_en   = 1'b1;
                                o_mreq.rd_addr = r_tail;
                                n_state        = S_SRCH0;
                            end
                        end
                        default: begin
                            n_status = cle_pkg::ST_MISS;
                        end
                    endcase
                end
            end

            // splice: new node takes the anchor's successor
            S_INS_RD: begin
                o_mreq.lk_we    = 1'b1;
                o_mreq.lk_waddr = r_n;
                o_mreq.lk_wdata = i_srsp.lk_rdata;
                n_state         = S_INS_WR;
            end

            // anchor now points at the new node
            S_INS_WR: begin
                o_mreq.lk_we    = 1'b1;
                o_mreq.lk_waddr = r_a;
                o_mreq.lk_wdata = r_n;
                if (r_req == cle_pkg::REQ_INS_BACK
                    || (r_req == cle_pkg::REQ_INS_AFTER && r_a == r_tail)) begin
                    n_tail = r_n;
                end
                n_count  = r_count + 1'b1;
                n_status = cle_pkg::ST_OK;
                n_res    = r_n;
                n_state  = S_DONE;
            end

            // first node is the tail's successor
            S_DEL_X: begin
                n_x            = i_srsp.lk_rdata;
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = i_srsp.lk_rdata;
                n_state        = S_DEL_NX;
            end

            // keep the victim's successor, start the predecessor walk at the tail
            S_DEL_NX: begin
                n_nx           = i_srsp.lk_rdata;
                n_p            = r_tail;
                n_i            = '0;
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = r_tail;
                n_state        = S_WALK;
            end

            // one link per cycle until the predecessor is found or the bound hits
            S_WALK: begin
                if (i_srsp.lk_rdata == r_x) begin
                    n_state = S_DEL_WR;
                end else begin
                    n_p = i_srsp.lk_rdata;
                    if (r_i == CW'(cle_pkg::POOL_DEPTH - 1)) begin
                        n_state = S_DEL_WR;
                    end else begin
                        n_i            = r_i + 1'b1;
                        o_mreq.rd_en   = 1'b1;
                        o_mreq.rd_addr = i_srsp.lk_rdata;
                    end
                end
            end

            // unlink the victim and release its slot
            S_DEL_WR: begin
                o_mreq.lk_we    = 1'b1;
                o_mreq.lk_waddr = r_p;
                o_mreq.lk_wdata = r_nx;
                o_mreq.use_clr  = 1'b1;
                o_mreq.use_idx  = r_x;
                if (r_x == r_tail) begin
                    n_tail = r_p;
                end
                n_count  = r_count - 1'b1;
                n_status = cle_pkg::ST_OK;
                n_res    = r_x;
                n_state  = S_DONE;
            end

            // search starts at the first node
            S_SRCH0: begin
                n_x            = i_srsp.lk_rdata;
                n_i            = '0;
                o_mreq.rd_en   = 1'b1;
                o_mreq.rd_addr = i_srsp.lk_rdata;
                n_state        = S_SRCH;
            end

            // compare one node per cycle
            S_SRCH: begin
                if (i_srsp.vl_rdata == r_val) begin
                    n_status = cle_pkg::ST_OK;
                    n_res    = r_x;
                    n_state  = S_DONE;
                end else if (CW'(r_i + 1'b1) >= r_count) begin
                    n_status = cle_pkg::ST_MISS;
                    n_res    = '0;
                    n_state  = S_DONE;
                end else begin
                    n_x            = i_srsp.lk_rdata;
                    n_i            = r_i + 1'b1;
                    o_mreq.rd_en   = 1'b1;
                    o_mreq.rd_addr = i_srsp.lk_rdata;
                end
            end

            // wait for the response register to free up
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // response register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_res    = r_out_res;
        n_out_count  = r_out_count;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && (!r_out_valid || o_rsp.ready)) begin
            n_out_valid  = 1'b1;
            n_out_status = r_status;
            n_out_res    = r_res;
            n_out_count  = r_count;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_val        <= n_val;
        r_a          <= n_a;
        r_n          <= n_n;
        r_x          <= n_x;
        r_nx         <= n_nx;
        r_p          <= n_p;
        r_i          <= n_i;
        r_status     <= n_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_res    <= n_out_res;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.result_handle = cle_pkg::HANDLE_W'(r_out_res);
    assign o_rsp.node_count    = cle_pkg::COUNT_W'(r_out_count);

endmodule

[sv/circular_list_engine_core.sv]
// requests settled at once (rejections, first insert, last delete) need no store read;
// an insert into a non-empty list reads the anchor's link, then writes two links; deletes
// walk to the victim's predecessor and a search walks the nodes, one link read per cycle
// throughput: one request at a time, a new one taken while the previous response waits
// reset: synchronous active low, clears the list (count, tail, in-use flags) at once
// depends on cle_pkg, cle_if, cle_store and cle_ctrl
`timescale 1ns / 1ps

module circular_list_engine_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cle_req_if.sink   i_req,
    cle_rsp_if.source o_rsp
);

    cle_pkg::t_mem_req   w_mreq;
    cle_pkg::t_store_rsp w_srsp;

    // request sequencer
    cle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mreq  (w_mreq),
        .i_srsp  (w_srsp)
    );

    // node store
    cle_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mreq  (w_mreq),
        .o_srsp  (w_srsp)
    );

endmodule
